@@ hdl/trc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, rotor wiring tables and mod-26 helpers for the rotor cipher.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int unsigned ALPHA     = 26;
   localparam int unsigned MAX_PAIRS = 10;
   localparam int unsigned PAIR_W    = 10;
   localparam int unsigned LOW_W     = 60;
   localparam int unsigned HIGH_W    = 40;
   localparam int unsigned PAIRS_W   = MAX_PAIRS * PAIR_W;

   localparam logic [4:0] LAST_POS = 5'(ALPHA - 1);

   // item modes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_ZERO   = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_PLUG_LOW  = 2'd0;
   localparam logic [1:0] CSR_PLUG_HIGH = 2'd1;

   typedef logic [4:0] letter_type;

   typedef struct packed {
      logic       rst;     // position reset item, result is zero
      logic       bad;     // letter out of range, result is zero
      letter_type letter;
      letter_type pos_l;
      letter_type pos_m;
      letter_type pos_r;
   } item_type;

   localparam letter_type WIRE_LEFT [ALPHA] = '{
      5'd5, 5'd17, 5'd0, 5'd25, 5'd23, 5'd8, 5'd21, 5'd12, 5'd9, 5'd14,
      5'd20, 5'd1, 5'd3, 5'd15, 5'd4, 5'd18, 5'd19, 5'd6, 5'd10, 5'd7,
      5'd11, 5'd2, 5'd13, 5'd16, 5'd22, 5'd24};
   localparam letter_type WIRE_MIDDLE [ALPHA] = '{
      5'd18, 5'd10, 5'd4, 5'd0, 5'd9, 5'd15, 5'd1, 5'd19, 5'd25, 5'd8,
      5'd20, 5'd14, 5'd13, 5'd7, 5'd12, 5'd5, 5'd3, 5'd21, 5'd24, 5'd17,
      5'd11, 5'd22, 5'd2, 5'd16, 5'd6, 5'd23};
   localparam letter_type WIRE_RIGHT [ALPHA] = '{
      5'd13, 5'd6, 5'd20, 5'd24, 5'd10, 5'd16, 5'd23, 5'd9, 5'd7, 5'd5,
      5'd19, 5'd12, 5'd0, 5'd22, 5'd3, 5'd18, 5'd11, 5'd4, 5'd17, 5'd21,
      5'd15, 5'd1, 5'd2, 5'd8, 5'd25, 5'd14};
   localparam letter_type WIRE_REFLECT [ALPHA] = '{
      5'd8, 5'd18, 5'd7, 5'd15, 5'd9, 5'd24, 5'd10, 5'd2, 5'd0, 5'd4,
      5'd6, 5'd16, 5'd17, 5'd21, 5'd25, 5'd3, 5'd11, 5'd12, 5'd1, 5'd22,
      5'd23, 5'd13, 5'd19, 5'd20, 5'd5, 5'd14};

   // inverse wirings for the return path
   localparam letter_type INV_LEFT [ALPHA] = '{
      5'd2, 5'd11, 5'd21, 5'd12, 5'd14, 5'd0, 5'd17, 5'd19, 5'd5, 5'd8,
      5'd18, 5'd20, 5'd7, 5'd22, 5'd9, 5'd13, 5'd23, 5'd1, 5'd15, 5'd16,
      5'd10, 5'd6, 5'd24, 5'd4, 5'd25, 5'd3};
   localparam letter_type INV_MIDDLE [ALPHA] = '{
      5'd3, 5'd6, 5'd22, 5'd16, 5'd2, 5'd15, 5'd24, 5'd13, 5'd9, 5'd4,
      5'd1, 5'd20, 5'd14, 5'd12, 5'd11, 5'd5, 5'd23, 5'd19, 5'd0, 5'd7,
      5'd10, 5'd17, 5'd21, 5'd25, 5'd18, 5'd8};
   localparam letter_type INV_RIGHT [ALPHA] = '{
      5'd12, 5'd21, 5'd22, 5'd14, 5'd17, 5'd9, 5'd1, 5'd8, 5'd23, 5'd7,
      5'd4, 5'd16, 5'd11, 5'd0, 5'd25, 5'd20, 5'd5, 5'd18, 5'd15, 5'd10,
      5'd2, 5'd19, 5'd13, 5'd6, 5'd3, 5'd24};

   // (a + b) mod 26 for a, b below 26
   function automatic letter_type add_mod(input letter_type a, input letter_type b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 6'(ALPHA)) return 5'(s - 6'(ALPHA));
      return s[4:0];
   endfunction

   // (x - p) mod 26 for x, p below 26
   function automatic letter_type sub_mod(input letter_type x, input letter_type p);
      logic [5:0] s;
      s = {1'b0, x} + 6'(ALPHA) - {1'b0, p};
      if (x >= p) return x - p;
      return s[4:0];
   endfunction

endpackage

@@ hdl/three_rotor_reflector_cipher.sv @@
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, the register after the
// reflector and the result register, which drives rsp_valid.
// Throughput: one item per cycle; req_stall rises only when all three registers
// hold items and rsp_stall is high.
// Reset: synchronous, active high; clears rotor positions, plug pairs and all
// pipeline valid flags. No clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
// three_rotor_reflector_cipher
// Three-rotor reflector cipher with plugboard, one letter per item.
// ----------------------------------------------------------------------------
module three_rotor_reflector_cipher import trc_pkg::*; #(
   parameter int unsigned PLUG_PAIRS = 10
) (
   input  logic             clock,
   input  logic             reset,
   // input items
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [4:0]       req_letter_in,
   // result items
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [4:0]       rsp_letter_out,
   output logic             rsp_invalid,
   // register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [LOW_W-1:0] csr_wdata
);

   // plug pair registers
   logic [LOW_W-1:0]  plug_low_ff;
   logic [HIGH_W-1:0] plug_high_ff;

   // rotor positions, stepped at accept time so back-to-back items
   // see the positions left by the one before
   letter_type pos_l_ff, pos_m_ff, pos_r_ff;
   letter_type pos_l_in, pos_m_in, pos_r_in;

   logic     pipe_ready;
   logic     req_accept;
   logic     letter_ok;
   item_type item;

   assign csr_ready  = 1'b1;
   assign req_stall  = !pipe_ready;
   assign req_accept = req_valid && pipe_ready;
   assign letter_ok  = req_letter_in < 5'(ALPHA);

   always_ff @(posedge clock) begin
      if (reset) begin
         plug_low_ff  <= '0;
         plug_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         // unknown indexes fall through and are dropped
         if (csr_index == CSR_PLUG_LOW)  plug_low_ff  <= csr_wdata;
         if (csr_index == CSR_PLUG_HIGH) plug_high_ff <= csr_wdata[HIGH_W-1:0];
      end
   end

   // odometer stepping: right on every in-range letter, carry on wrap, no notches; zero items clear all
   always_comb begin
      pos_l_in = pos_l_ff;
      pos_m_in = pos_m_ff;
      pos_r_in = pos_r_ff;
      if (req_accept) begin
         if (req_mode == MODE_ZERO) begin
            pos_l_in = '0;
            pos_m_in = '0;
            pos_r_in = '0;
         end else if (letter_ok) begin
            if (pos_r_ff == LAST_POS) begin
               pos_r_in = '0;
               if (pos_m_ff == LAST_POS) begin
                  pos_m_in = '0;
                  pos_l_in = (pos_l_ff == LAST_POS) ? '0 : pos_l_ff + 5'd1;
               end else begin
                  pos_m_in = pos_m_ff + 5'd1;
               end
            end else begin
               pos_r_in = pos_r_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_l_ff <= '0;
         pos_m_ff <= '0;
         pos_r_ff <= '0;
      end else begin
         pos_l_ff <= pos_l_in;
         pos_m_ff <= pos_m_in;
         pos_r_ff <= pos_r_in;
      end
   end

   // item carries the positions after its own step
   always_comb begin
      item.rst    = (req_mode == MODE_ZERO);
      item.bad    = (req_mode == MODE_ENCODE) && !letter_ok;
      item.letter = letter_ok ? req_letter_in : '0;
      item.pos_l  = pos_l_in;
      item.pos_m  = pos_m_in;
      item.pos_r  = pos_r_in;
   end

   trc_pipe #(.PLUG_PAIRS(PLUG_PAIRS)) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .pairs      ({plug_high_ff, plug_low_ff}),
      .in_valid   (req_valid),
      .in_item    (item),
      .in_ready   (pipe_ready),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_letter (rsp_letter_out),
      .out_invalid(rsp_invalid)
   );

endmodule

@@ hdl/trc_plugboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_plugboard
// Plugboard swap: first active pair that holds the letter swaps it.
// ----------------------------------------------------------------------------
module trc_plugboard import trc_pkg::*; #(
   parameter int unsigned PLUG_PAIRS = 10
) (
   input  logic [PAIRS_W-1:0] pairs,
   input  letter_type         letter_in,
   output letter_type         letter_out
);

   always_comb begin
      logic       found;
      letter_type a;
      letter_type b;
      found      = 1'b0;
      letter_out = letter_in;
      for (int i = 0; i < PLUG_PAIRS; i++) begin
         a = pairs[i*PAIR_W +: 5];
         b = pairs[i*PAIR_W + 5 +: 5];
         // equal ends or an out-of-range end mean the pair is unused
         if (!found && a != b && a < 5'(ALPHA) && b < 5'(ALPHA)) begin
            if (letter_in == a) begin
               letter_out = b;
               found      = 1'b1;
            end else if (letter_in == b) begin
               letter_out = a;
               found      = 1'b1;
            end
         end
      end
   end

endmodule

@@ hdl/trc_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pipe
// Input register, forward/reflect stage, return stage and result register.
// ----------------------------------------------------------------------------
module trc_pipe import trc_pkg::*; #(
   parameter int unsigned PLUG_PAIRS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PAIRS_W-1:0] pairs,
   input  logic               in_valid,
   input  item_type           in_item,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_stall,
   output letter_type         out_letter,
   output logic               out_invalid
);

   logic       s1_valid_ff, s2_valid_ff, o_valid_ff;
   item_type   s1_ff, s2_ff;
   letter_type o_letter_ff;
   logic       o_invalid_ff;

   logic       o_adv, s2_adv, s1_adv;
   letter_type fwd_plug, fwd_r, fwd_m, fwd_l, refl;
   letter_type back_l, back_m, back_r, back_plug;
   item_type   s2_in;

   assign o_adv    = !o_valid_ff || !out_stall;
   assign s2_adv   = !s2_valid_ff || o_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // forward path through plugboard, rotors and reflector
   trc_plugboard #(.PLUG_PAIRS(PLUG_PAIRS)) u_plug_fwd (
      .pairs     (pairs),
      .letter_in (s1_ff.letter),
      .letter_out(fwd_plug)
   );

   always_comb begin
      fwd_r = WIRE_RIGHT[add_mod(s1_ff.pos_r, fwd_plug)];
      fwd_m = WIRE_MIDDLE[add_mod(s1_ff.pos_m, fwd_r)];
      fwd_l = WIRE_LEFT[add_mod(s1_ff.pos_l, fwd_m)];
      refl  = WIRE_REFLECT[fwd_l];
      s2_in        = s1_ff;
      s2_in.letter = refl;
   end

   // return path through inverse rotors and plugboard
   always_comb begin
      back_l = sub_mod(INV_LEFT[s2_ff.letter], s2_ff.pos_l);
      back_m = sub_mod(INV_MIDDLE[back_l], s2_ff.pos_m);
      back_r = sub_mod(INV_RIGHT[back_m], s2_ff.pos_r);
   end

   trc_plugboard #(.PLUG_PAIRS(PLUG_PAIRS)) u_plug_back (
      .pairs     (pairs),
      .letter_in (back_r),
      .letter_out(back_plug)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (o_adv)  o_valid_ff  <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) s1_ff <= in_item;
      if (s2_adv && s1_valid_ff) s2_ff <= s2_in;
      if (o_adv && s2_valid_ff) begin
         o_letter_ff  <= (s2_ff.rst || s2_ff.bad) ? '0 : back_plug;
         o_invalid_ff <= s2_ff.bad;
      end
   end

   assign out_valid   = o_valid_ff;
   assign out_letter  = o_letter_ff;
   assign out_invalid = o_invalid_ff;

endmodule

@@ hdl/trc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks on the rotor cipher, bound to the top level.
// ----------------------------------------------------------------------------
module trc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [4:0] rsp_letter_out,
   input logic       rsp_invalid
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input only backs up when the result side is full and stalled
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req_stall without a stalled result");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_letter_out < 5'd26)
      else $error("letter_out out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> rsp_letter_out == 5'd0)
      else $error("invalid item with nonzero letter");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

endmodule

bind three_rotor_reflector_cipher trc_checker u_trc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_letter_out(rsp_letter_out),
   .rsp_invalid   (rsp_invalid)
);
